>>> rtl/rbcg_pkg.sv
// ----------------------------------------------------------------------------
// Ring buffer chunk grant: shared package
// Field widths, default ring depth and function codes of the grant engine.
// ----------------------------------------------------------------------------
package rbcg_pkg;

  // Default ring depth in bytes
  localparam int unsigned DEPTH_DEF  = 4096;

  // Fixed port widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned GRANT_W    = 13;
  localparam int unsigned PEND_W     = 13;

  // Ring size after reset, before clamping to the depth
  localparam int unsigned SIZE_RESET = 4096;

  // Request functions
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

endpackage

>>> rtl/rbcg_grant.sv
// ----------------------------------------------------------------------------
// Ring buffer chunk grant: grant unit
// Computes the granted region, error flag and next ring indices for one
// request from the current ring state.
// ----------------------------------------------------------------------------
module rbcg_grant #(
  parameter int unsigned DEPTH = rbcg_pkg::DEPTH_DEF
) (
  input  rbcg_pkg::func_e                    func_i,
  input  logic [rbcg_pkg::COUNT_W-1:0]       count_i,
  input  logic [$clog2(DEPTH+1)-1:0]         size_i,
  input  logic [$clog2(DEPTH)-1:0]           widx_i,
  input  logic [$clog2(DEPTH)-1:0]           ridx_i,
  input  logic [$clog2(DEPTH+1)-1:0]         fill_i,
  output logic                               error_o,
  output logic [$clog2(DEPTH)-1:0]           start_o,
  output logic [$clog2(DEPTH+1)-1:0]         granted_o,
  output logic [$clog2(DEPTH)-1:0]           widx_o,
  output logic [$clog2(DEPTH)-1:0]           ridx_o,
  output logic [$clog2(DEPTH+1)-1:0]         fill_o
);
  import rbcg_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] wr, rd, num_c;
  logic [CW-1:0] wr_free, rd_avail, room, sz, wi_eff;
  logic [CW:0]   wr_adv, rd_adv;

  // Indices widened to the ring size width; request count capped at ring size
  assign wr    = CW'(widx_i);
  assign rd    = CW'(ridx_i);
  assign num_c = (32'(count_i) > 32'(size_i)) ? size_i : CW'(count_i);
  assign room  = size_i - fill_i;

  // Contiguous free region ahead of the write index, with wrap at ring end
  always_comb begin
    wi_eff = wr;
    if (wr >= rd) begin
      wr_free = (wr < size_i) ? (size_i - wr) : '0;
      if ((wr_free == '0) && (rd != '0)) begin
        wi_eff  = '0;
        wr_free = rd;
      end
    end else begin
      wr_free = rd - wr;
    end
  end

  // Contiguous filled region ahead of the read index, limited by fill
  always_comb begin
    if (wr > rd) begin
      rd_avail = wr - rd;
    end else begin
      rd_avail = (rd < size_i) ? (size_i - rd) : '0;
    end
    if (rd_avail > fill_i) begin
      rd_avail = fill_i;
    end
  end

  // Grant per function and advance indices with one wrap subtract
  always_comb begin
    error_o   = 1'b0;
    start_o   = widx_i;
    granted_o = '0;
    widx_o    = widx_i;
    ridx_o    = ridx_i;
    fill_o    = fill_i;
    sz        = '0;
    wr_adv    = '0;
    rd_adv    = '0;
    case (func_i)
      FUNC_WRITE: begin
        if (count_i != '0) begin
          if (fill_i >= size_i) begin
            error_o = 1'b1;
          end else begin
            sz = wr_free;
            if (sz > room) begin
              sz = room;
            end
            if (sz > num_c) begin
              sz = num_c;
            end
            start_o = IW'(wi_eff);
            widx_o  = IW'(wi_eff);
            if (sz == '0) begin
              error_o = 1'b1;
            end else begin
              granted_o = sz;
              wr_adv    = {1'b0, wi_eff} + {1'b0, sz};
              if (wr_adv >= {1'b0, size_i}) begin
                wr_adv = wr_adv - {1'b0, size_i};
              end
              widx_o = IW'(wr_adv);
              fill_o = fill_i + sz;
            end
          end
        end
      end
      FUNC_READ: begin
        start_o = ridx_i;
        if (count_i != '0) begin
          if (fill_i == '0) begin
            error_o = 1'b1;
          end else begin
            sz = rd_avail;
            if (sz > num_c) begin
              sz = num_c;
            end
            if (sz == '0) begin
              error_o = 1'b1;
            end else begin
              granted_o = sz;
              rd_adv    = {1'b0, rd} + {1'b0, sz};
              if (rd_adv >= {1'b0, size_i}) begin
                rd_adv = rd_adv - {1'b0, size_i};
              end
              ridx_o = IW'(rd_adv);
              fill_o = fill_i - sz;
              // Drained: return both indices to the ring start
              if (fill_o == '0) begin
                widx_o = '0;
                ridx_o = '0;
              end
            end
          end
        end
      end
      FUNC_PEEK: begin
        start_o = ridx_i;
        if (fill_i == '0) begin
          error_o = 1'b1;
        end else begin
          granted_o = rd_avail;
        end
      end
      default: begin
        start_o = '0;
        widx_o  = '0;
        ridx_o  = '0;
        fill_o  = '0;
      end
    endcase
  end

endmodule

>>> rtl/ring_buffer_chunk_grant.sv
// ----------------------------------------------------------------------------
// Ring buffer chunk grant: top level
// Index and grant engine of a byte ring buffer with write, read, peek and
// clear requests against a configurable ring size.
// ----------------------------------------------------------------------------
// A request is taken whenever start_i is high; busy_o stays low, so one
// request can be issued every cycle. The request is registered at the edge
// that takes it, the grant is computed from the ring state in the following
// cycle, and the result is registered onto the result ports, with done_o
// high for exactly one cycle. The receiver cannot stall, so results must be
// captured when done_o is high.
// The ring state updates as each result is registered, so back-to-back
// requests see each other's effect. Writing the ring size empties the
// ring; the user must do so only while no request is in flight, as the block
// does not enforce it. Sizes of zero act as one, sizes above DEPTH as DEPTH.
// ----------------------------------------------------------------------------
module ring_buffer_chunk_grant #(
  parameter int unsigned DEPTH = rbcg_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [rbcg_pkg::FUNC_W-1:0]     func_i,
  input  logic [rbcg_pkg::COUNT_W-1:0]    request_count_i,
  // Ring size configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rbcg_pkg::SIZE_W-1:0]     cfg_buffer_size_i,
  // Result
  output logic                            done_o,
  output logic                            error_o,
  output logic [rbcg_pkg::OFFSET_W-1:0]   start_offset_o,
  output logic [rbcg_pkg::GRANT_W-1:0]    granted_count_o,
  output logic [rbcg_pkg::PEND_W-1:0]     pending_bytes_o
);
  import rbcg_pkg::*;

  localparam int unsigned IW       = $clog2(DEPTH);
  localparam int unsigned CW       = $clog2(DEPTH + 1);
  localparam int unsigned SIZE_RST = (SIZE_RESET > DEPTH) ? DEPTH : SIZE_RESET;

  logic                req_valid_q;
  func_e               req_func_q;
  logic [COUNT_W-1:0]  req_count_q;

  logic [CW-1:0]       size_q, size_d;
  logic [IW-1:0]       widx_q, ridx_q;
  logic [CW-1:0]       fill_q;

  logic                g_error;
  logic [IW-1:0]       g_start, g_widx, g_ridx;
  logic [CW-1:0]       g_granted, g_fill;

  logic                done_q;
  logic                error_q;
  logic [OFFSET_W-1:0] start_q;
  logic [GRANT_W-1:0]  granted_q;
  logic [PEND_W-1:0]   pending_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Clamp the written ring size into one to DEPTH
  always_comb begin
    if (cfg_buffer_size_i == '0) begin
      size_d = CW'(1);
    end else if (32'(cfg_buffer_size_i) > 32'(DEPTH)) begin
      size_d = CW'(DEPTH);
    end else begin
      size_d = CW'(cfg_buffer_size_i);
    end
  end

  // Capture request valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
    end
  end

  // Capture request payload
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_func_q  <= func_e'(func_i);
      req_count_q <= request_count_i;
    end
  end

  rbcg_grant #(
    .DEPTH (DEPTH)
  ) u_grant (
    .func_i    (req_func_q),
    .count_i   (req_count_q),
    .size_i    (size_q),
    .widx_i    (widx_q),
    .ridx_i    (ridx_q),
    .fill_i    (fill_q),
    .error_o   (g_error),
    .start_o   (g_start),
    .granted_o (g_granted),
    .widx_o    (g_widx),
    .ridx_o    (g_ridx),
    .fill_o    (g_fill)
  );

  // Update ring state on a size write or a granted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CW'(SIZE_RST);
      widx_q <= '0;
      ridx_q <= '0;
      fill_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= size_d;
      widx_q <= '0;
      ridx_q <= '0;
      fill_q <= '0;
    end else if (req_valid_q) begin
      widx_q <= g_widx;
      ridx_q <= g_ridx;
      fill_q <= g_fill;
    end
  end

  // Strobe the result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_valid_q;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      error_q   <= g_error;
      start_q   <= OFFSET_W'(g_start);
      granted_q <= GRANT_W'(g_granted);
      pending_q <= PEND_W'(g_fill);
    end
  end

  assign done_o          = done_q;
  assign error_o         = error_q;
  assign start_offset_o  = start_q;
  assign granted_count_o = granted_q;
  assign pending_bytes_o = pending_q;

endmodule

>>> test/ring_grant_checker.sv
// ----------------------------------------------------------------------------
// Ring buffer chunk grant: result checker
// Watches the request, ring size and result channels of the grant engine,
// predicts each grant from its own copy of the ring indices and occupancy,
// and compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ring_grant_checker #(
  parameter int unsigned DEPTH = rbcg_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [rbcg_pkg::FUNC_W-1:0]   func_i,
  input  logic [rbcg_pkg::COUNT_W-1:0]  request_count_i,
  // Ring size channel
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [rbcg_pkg::SIZE_W-1:0]   cfg_buffer_size_i,
  // Result
  input  logic                          done_i,
  input  logic                          error_i,
  input  logic [rbcg_pkg::OFFSET_W-1:0] start_offset_i,
  input  logic [rbcg_pkg::GRANT_W-1:0]  granted_count_i,
  input  logic [rbcg_pkg::PEND_W-1:0]   pending_bytes_i,
  // Status towards the stimulus side
  output int                            fail_count_o,
  output int                            outstanding_o,
  output int                            checked_o
);

  import rbcg_pkg::*;

  typedef struct packed {
    logic                err;
    logic [OFFSET_W-1:0] offset;
    logic [GRANT_W-1:0]  granted;
    logic [PEND_W-1:0]   pending;
  } grant_t;

  // Model copy of the ring
  logic [SIZE_W-1:0] ring_cfg;
  int unsigned       wr_idx;
  int unsigned       rd_idx;
  int unsigned       fill;

  grant_t grants_due[$];
  int     fail_count = 0;
  int     due_count  = 0;
  int     checked    = 0;

  assign fail_count_o  = fail_count;
  assign outstanding_o = due_count;
  assign checked_o     = checked;

  // Effective ring size: zero acts as one, oversize acts as the depth
  function automatic int unsigned ring_len();
    int unsigned s;
    s = ring_cfg;
    if (s < 1) s = 1;
    if (s > DEPTH) s = DEPTH;
    return s;
  endfunction

  function automatic void empty_ring();
    wr_idx = 0;
    rd_idx = 0;
    fill   = 0;
  endfunction

  // Contiguous filled bytes from the read index, capped by occupancy
  function automatic int unsigned readable(int unsigned size);
    int unsigned sz;
    if (wr_idx > rd_idx) sz = wr_idx - rd_idx;
    else sz = (rd_idx < size) ? size - rd_idx : 0;
    if (sz > fill) sz = fill;
    return sz;
  endfunction

  // Compute the grant of one request and advance the model ring
  function automatic grant_t grant_for(func_e fn, int unsigned num);
    int unsigned size;
    int unsigned sz;
    grant_t      g;
    size = ring_len();
    g    = '0;
    case (fn)
      FUNC_WRITE: begin
        g.offset = wr_idx[OFFSET_W-1:0];
        if (num != 0) begin
          if (fill >= size) begin
            g.err = 1'b1;
          end else begin
            if (wr_idx >= rd_idx) begin
              sz = (wr_idx < size) ? size - wr_idx : 0;
              // wrap to the ring start when parked at the end
              if (sz == 0 && rd_idx > 0) begin
                wr_idx = 0;
                sz     = rd_idx;
              end
            end else begin
              sz = rd_idx - wr_idx;
            end
            if (sz > size - fill) sz = size - fill;
            if (sz > num) sz = num;
            g.offset = wr_idx[OFFSET_W-1:0];
            if (sz == 0) begin
              g.err = 1'b1;
            end else begin
              g.granted = sz[GRANT_W-1:0];
              wr_idx    = (wr_idx + sz) % size;
              fill      = fill + sz;
            end
          end
        end
      end
      FUNC_READ: begin
        g.offset = rd_idx[OFFSET_W-1:0];
        if (num != 0) begin
          if (fill == 0) begin
            g.err = 1'b1;
          end else begin
            sz = readable(size);
            if (sz > num) sz = num;
            if (sz == 0) begin
              g.err = 1'b1;
            end else begin
              g.granted = sz[GRANT_W-1:0];
              rd_idx    = (rd_idx + sz) % size;
              fill      = fill - sz;
              if (fill == 0) empty_ring();
            end
          end
        end
      end
      FUNC_PEEK: begin
        g.offset = rd_idx[OFFSET_W-1:0];
        if (fill == 0) begin
          g.err = 1'b1;
        end else begin
          sz        = readable(size);
          g.granted = sz[GRANT_W-1:0];
        end
      end
      default: begin
        empty_ring();
      end
    endcase
    g.pending = fill[PEND_W-1:0];
    return g;
  endfunction

  // Check results, track ring size writes, predict accepted requests
  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t got;
    grant_t want;
    if (!rst_ni) begin
      ring_cfg = SIZE_W'(SIZE_RESET);
      empty_ring();
      grants_due.delete();
      due_count  = 0;
      fail_count = 0;
      checked    = 0;
    end else begin
      // compare first: a result always belongs to an earlier request
      if (done_i) begin
        got.err     = error_i;
        got.offset  = start_offset_i;
        got.granted = granted_count_i;
        got.pending = pending_bytes_i;
        if (grants_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: err=%0d off=%0d grant=%0d pend=%0d",
                     got.err, got.offset, got.granted, got.pending);
        end else begin
          want = grants_due.pop_front();
          checked++;
          if (got.err !== want.err || got.offset !== want.offset ||
              got.granted !== want.granted || got.pending !== want.pending) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("grant mismatch: expected err=%0d off=%0d grant=%0d pend=%0d,",
                     want.err, want.offset, want.granted, want.pending);
              $display(" got err=%0d off=%0d grant=%0d pend=%0d",
                       got.err, got.offset, got.granted, got.pending);
            end
          end
        end
      end
      // take a new ring size and empty the ring
      if (cfg_valid_i && cfg_ready_i) begin
        ring_cfg = cfg_buffer_size_i;
        empty_ring();
      end
      // predict the accepted request
      if (start_i && !busy_i)
        grants_due.push_back(grant_for(func_e'(func_i), request_count_i));
      due_count = grants_due.size();
    end
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Ring buffer chunk grant: testbench top
// Drives directed and random write, read, peek and clear requests across a
// range of ring sizes with random gaps; the checker beside the engine
// predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  import rbcg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 98;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [FUNC_W-1:0]   func_i;
  logic [COUNT_W-1:0]  request_count_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [SIZE_W-1:0]   cfg_buffer_size_i;
  logic                done_o;
  logic                error_o;
  logic [OFFSET_W-1:0] start_offset_o;
  logic [GRANT_W-1:0]  granted_count_o;
  logic [PEND_W-1:0]   pending_bytes_o;

  int          fail_count;
  int          outstanding;
  int          checked;
  int unsigned cycles;
  int          requests_sent = 0;
  int          sizes_used    = 0;
  int unsigned ring_len_tb   = DEPTH_DEF;

  ring_buffer_chunk_grant dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .func_i            (func_i),
    .request_count_i   (request_count_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_buffer_size_i (cfg_buffer_size_i),
    .done_o            (done_o),
    .error_o           (error_o),
    .start_offset_o    (start_offset_o),
    .granted_count_o   (granted_count_o),
    .pending_bytes_o   (pending_bytes_o)
  );

  ring_grant_checker #(.DEPTH(DEPTH_DEF)) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .func_i            (func_i),
    .request_count_i   (request_count_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_buffer_size_i (cfg_buffer_size_i),
    .done_i            (done_o),
    .error_i           (error_o),
    .start_offset_i    (start_offset_o),
    .granted_count_i   (granted_count_o),
    .pending_bytes_i   (pending_bytes_o),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding),
    .checked_o         (checked)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Issue one request and hold it until the engine takes it
  task automatic issue(func_e fn, int unsigned count);
    bit taken;
    start_i         <= 1'b1;
    func_i          <= fn;
    request_count_i <= count[COUNT_W-1:0];
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    requests_sent++;
  endtask

  // Drop start for a number of cycles
  task automatic idle(int unsigned n);
    if (n != 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold off until every predicted result has come back
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  // Write a new ring size while the engine is idle
  task automatic set_ring(int unsigned size);
    bit taken;
    drain();
    repeat (4) @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_buffer_size_i <= size[SIZE_W-1:0];
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    ring_len_tb = size[SIZE_W-1:0];
    if (ring_len_tb < 1) ring_len_tb = 1;
    if (ring_len_tb > DEPTH_DEF) ring_len_tb = DEPTH_DEF;
    sizes_used++;
  endtask

  // Bias toward writes and reads, clears are rare
  function automatic func_e pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return FUNC_WRITE;
    else if (r < 75) return FUNC_READ;
    else if (r < 92) return FUNC_PEEK;
    else return FUNC_CLEAR;
  endfunction

  // Counts mostly within the ring, some zero, some full width
  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    else if (r < 14) return $urandom_range(0, 65535);
    else if (r < 30) return ring_len_tb + $urandom_range(0, 3);
    else return $urandom_range(1, ring_len_tb / 2 + 1);
  endfunction

  // Mostly short gaps, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(10, 40);
  endfunction

  // Stimulus
  initial begin : stimulus
    int unsigned ring_sizes[10];
    bit          no_gaps;
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    func_i            = FUNC_WRITE;
    request_count_i   = '0;
    cfg_valid_i       = 1'b0;
    cfg_buffer_size_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty ring, zero counts, fill up, refuse when full, wrap
    issue(FUNC_READ, 5);
    issue(FUNC_PEEK, 0);
    issue(FUNC_WRITE, 0);
    issue(FUNC_READ, 0);
    issue(FUNC_WRITE, 16'hFFFF);
    issue(FUNC_WRITE, 1);
    issue(FUNC_PEEK, 16'hFFFF);
    issue(FUNC_READ, 1);
    issue(FUNC_WRITE, 16'hAAAA);
    idle(3);
    issue(FUNC_READ, 4000);
    issue(FUNC_PEEK, 0);
    issue(FUNC_READ, 16'h5555);
    issue(FUNC_READ, 1);
    issue(FUNC_CLEAR, 0);
    issue(FUNC_WRITE, 100);
    issue(FUNC_CLEAR, 16'hFFFF);
    issue(FUNC_PEEK, 7);
    issue(FUNC_WRITE, 4096);
    idle(1);
    issue(FUNC_READ, 2048);
    issue(FUNC_WRITE, 5000);
    issue(FUNC_READ, 0);
    issue(FUNC_WRITE, 0);
    issue(FUNC_READ, 16'hFFFF);
    issue(FUNC_READ, 16'hFFFF);
    drain();

    // Random phases over ring sizes, the extremes among them
    ring_sizes[0] = 1;
    ring_sizes[1] = 0;
    ring_sizes[2] = 2;
    ring_sizes[3] = 8191;
    ring_sizes[4] = 3;
    ring_sizes[5] = 4096;
    ring_sizes[6] = 7;
    ring_sizes[7] = 64;
    ring_sizes[8] = $urandom_range(1, 4095);
    ring_sizes[9] = $urandom_range(0, 8191);
    for (int p = 0; p < 10; p++) begin
      set_ring(ring_sizes[p]);
      no_gaps = (p % 3 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        issue(pick_func(), pick_count());
        if (!no_gaps) idle(pick_gap());
        // pause the sender mid-phase until the engine has caught up
        if (i == PHASE_ITEMS / 2 && p % 2 == 0) drain();
      end
    end

    // Wait out the last results
    drain();
    repeat (8) @(posedge clk_i);
    $display("summary: %0d requests over %0d ring size settings, %0d results checked",
             requests_sent, sizes_used, checked);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Cycle limit
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/rbcg_pkg.sv
rtl/rbcg_grant.sv
rtl/ring_buffer_chunk_grant.sv
test/ring_grant_checker.sv
test/testbench.sv
